FILE: design/vn2c_pkg.sv
// shared types, constants and the blend weight function for the value noise block
package vn2c_pkg;

	localparam int unsigned DATA_W   = 32;
	localparam int unsigned WEIGHT_W = 17;
	localparam int unsigned SMOOTH_W = 36;
	localparam int unsigned OUT_W    = 18;

	localparam logic [31:0] HASH_MUL_A = 32'd15731;
	localparam logic [31:0] HASH_MUL_B = 32'd789221;
	localparam logic [31:0] HASH_ADD   = 32'd6871;
	localparam logic signed [31:0] LAT_ONE = 32'sh4000_0000;

	localparam logic [63:0] PI_Q30 = 64'd3373259426;
	localparam logic [63:0] TERM_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
		64'd156, 64'd210};

	localparam logic [0:0] REG_SEED_A = 1'b0;
	localparam logic [0:0] REG_SEED_B = 1'b1;

	typedef struct packed {
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} hash_en_t;

	// sin^2(pi*k/2^(tbits+1)) in Q16 by a truncated taylor series
	function automatic logic [WEIGHT_W-1:0] blend_weight(input logic [31:0] k,
		input int unsigned tbits);
		logic [63:0] th;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] p;
		th = (PI_Q30 * {32'd0, k}) >> (tbits + 1);
		t = th;
		s = th;
		for (int m = 1; m <= 7; m++) begin
			t = (t * th) >> 30;
			t = (t * th) >> 30;
			t = t / TERM_DIV[m];
			if ((m & 1) == 1) begin
				s = (s >= t) ? s - t : 64'd0;
			end else begin
				s = s + t;
			end
		end
		if (s > 64'h4000_0000) begin
			s = 64'h4000_0000;
		end
		p = s * s + (64'd1 << 43);
		return p[60:44];
	endfunction

endpackage

FILE: design/vn2c_sample_if.sv
// input channel: sample point transaction
interface vn2c_sample_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] x_pos;
	logic signed [31:0] y_pos;

	modport source (output valid, output x_pos, output y_pos, input ready);
	modport sink (input valid, input x_pos, input y_pos, output ready);
endinterface

FILE: design/vn2c_noise_if.sv
// output channel: noise result transaction
interface vn2c_noise_if;
	logic               valid;
	logic               ready;
	logic signed [17:0] noise_value;

	modport source (output valid, output noise_value, input ready);
	modport sink (input valid, input noise_value, output ready);
endinterface

FILE: design/vn2c_weight_rom.sv
// cosine blend weight table with registered read
module vn2c_weight_rom #(
	parameter int WEIGHT_TABLE_BITS = 10
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic [WEIGHT_TABLE_BITS-1:0]   idx,
	output logic [vn2c_pkg::WEIGHT_W-1:0]  weight
);

	localparam int DEPTH = 1 << WEIGHT_TABLE_BITS;

	logic [vn2c_pkg::WEIGHT_W-1:0] tab [DEPTH];

	for (genvar gk = 0; gk < DEPTH; gk++) begin : g_tab
		assign tab[gk] = vn2c_pkg::blend_weight(32'(gk), WEIGHT_TABLE_BITS);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			weight <= tab[idx];
		end
	end

endmodule

FILE: design/vn2c_hash_lane.sv
// one lattice point: integer hash pipeline giving the q30 lattice value
module vn2c_hash_lane (
	input  logic                   clk,
	input  vn2c_pkg::hash_en_t     en,
	input  logic [31:0]            v_in,
	output logic signed [31:0]     lat_s6
);

	logic [31:0] v_s3;
	logic [31:0] v_s4;
	logic [31:0] sq_s4;
	logic [31:0] v_s5;
	logic [31:0] p_s5;
	logic [31:0] h;

	assign h = v_s5 * p_s5 + vn2c_pkg::HASH_ADD;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			v_s3 <= v_in;
		end
		if (en.s4) begin
			v_s4  <= v_s3;
			sq_s4 <= v_s3 * v_s3;
		end
		if (en.s5) begin
			v_s5 <= v_s4;
			p_s5 <= sq_s4 * vn2c_pkg::HASH_MUL_B + vn2c_pkg::HASH_MUL_A;
		end
		if (en.s6) begin
			lat_s6 <= vn2c_pkg::LAT_ONE - signed'({1'b0, h[30:0]});
		end
	end

endmodule

FILE: design/vn2c_blend.sv
// linear blend a*(1-w) + b*w in q34, floored
module vn2c_blend (
	input  logic signed [vn2c_pkg::SMOOTH_W-1:0] a,
	input  logic signed [vn2c_pkg::SMOOTH_W-1:0] b,
	input  logic [vn2c_pkg::WEIGHT_W-1:0]        w,
	output logic signed [vn2c_pkg::SMOOTH_W-1:0] y
);

	localparam int DW = vn2c_pkg::SMOOTH_W + 1;
	localparam int PW = DW + vn2c_pkg::WEIGHT_W + 1;

	logic signed [DW-1:0] diff;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] total;

	always_comb begin
		diff  = DW'(b) - DW'(a);
		prod  = PW'(diff) * PW'(signed'({1'b0, w}));
		total = (PW'(a) <<< 16) + prod;
		y     = vn2c_pkg::SMOOTH_W'(total >>> 16);
	end

endmodule

FILE: design/value_noise_2d_cosine_top.sv
// seeded 2d value noise with cosine blend, top level
// pipeline of nine register stages from the accepting edge to a valid result
// throughput: one sample per cycle while noise.ready is high, with per-stage stall
// each stage advances when it is empty or the next one advances; bubbles are squeezed
// reset: arst_n clears the stage valid bits and both seeds to zero; no clearing pass
module value_noise_2d_cosine_top #(
	parameter int FRAC_BITS         = 16,
	parameter int WEIGHT_TABLE_BITS = 10
) (
	input  logic         clk,
	input  logic         arst_n,
	vn2c_sample_if.sink  sample,
	vn2c_noise_if.source noise,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int SW = vn2c_pkg::SMOOTH_W;
	localparam int WW = vn2c_pkg::WEIGHT_W;

	// configuration
	logic [31:0] seed_a_q;
	logic [31:0] seed_b_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == vn2c_pkg::REG_SEED_B) ? seed_b_q : seed_a_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_a_q <= '0;
			seed_b_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				vn2c_pkg::REG_SEED_A: seed_a_q <= pwdata;
				vn2c_pkg::REG_SEED_B: seed_b_q <= pwdata;
				default: ;
			endcase
		end
	end

	// stage handshake
	logic [9:1]  vld;
	logic [10:1] adv;

	assign adv[10] = noise.ready;
	for (genvar gs = 1; gs <= 9; gs++) begin : g_adv
		assign adv[gs] = !vld[gs] || adv[gs+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (adv[1]) vld[1] <= sample.valid;
			for (int k = 2; k <= 9; k++) begin
				if (adv[k]) vld[k] <= vld[k-1];
			end
		end
	end

	assign sample.ready = adv[1];
	assign noise.valid  = vld[9];

	// stage 1: split coordinates, seed terms
	logic [31:0] mag_x, mag_y, ip_x, ip_y;
	logic [WEIGHT_TABLE_BITS-1:0] kx, ky;

	always_comb begin
		mag_x = sample.x_pos[31] ? 32'(-sample.x_pos) : 32'(sample.x_pos);
		mag_y = sample.y_pos[31] ? 32'(-sample.y_pos) : 32'(sample.y_pos);
		ip_x  = sample.x_pos[31] ? 32'(0) - (mag_x >> FRAC_BITS) : (mag_x >> FRAC_BITS);
		ip_y  = sample.y_pos[31] ? 32'(0) - (mag_y >> FRAC_BITS) : (mag_y >> FRAC_BITS);
	end

	if (FRAC_BITS >= WEIGHT_TABLE_BITS) begin : g_idx_cut
		assign kx = mag_x[FRAC_BITS-1 -: WEIGHT_TABLE_BITS];
		assign ky = mag_y[FRAC_BITS-1 -: WEIGHT_TABLE_BITS];
	end else begin : g_idx_pad
		assign kx = {mag_x[FRAC_BITS-1:0], {(WEIGHT_TABLE_BITS-FRAC_BITS){1'b0}}};
		assign ky = {mag_y[FRAC_BITS-1:0], {(WEIGHT_TABLE_BITS-FRAC_BITS){1'b0}}};
	end

	logic [31:0] ix_s1, iy_s1, ca_s1, cb_s1, sab_s1;
	logic [WEIGHT_TABLE_BITS-1:0] kx_s1, ky_s1;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			ix_s1  <= ip_x;
			iy_s1  <= ip_y;
			kx_s1  <= kx;
			ky_s1  <= ky;
			ca_s1  <= 32'd7 * seed_a_q + seed_b_q;
			cb_s1  <= seed_a_q - 32'd17 * seed_b_q;
			sab_s1 <= seed_a_q * seed_b_q;
		end
	end

	// stage 2: per-column and per-row hash terms, weight lookup
	logic [31:0] xt_s2 [4];
	logic [31:0] yt_s2 [4];
	logic [31:0] sab_s2;
	logic [WW-1:0] wx_s2, wy_s2;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			for (int d = 0; d < 4; d++) begin
				xt_s2[d] <= (ix_s1 + ca_s1 + 32'(d) - 32'd1) << 16;
				yt_s2[d] <= (iy_s1 + cb_s1 + 32'(d) - 32'd1) * vn2c_pkg::HASH_MUL_A;
			end
			sab_s2 <= sab_s1;
		end
	end

	vn2c_weight_rom #(.WEIGHT_TABLE_BITS(WEIGHT_TABLE_BITS)) u_rom_x (
		.clk(clk), .en(adv[2]), .idx(kx_s1), .weight(wx_s2)
	);
	vn2c_weight_rom #(.WEIGHT_TABLE_BITS(WEIGHT_TABLE_BITS)) u_rom_y (
		.clk(clk), .en(adv[2]), .idx(ky_s1), .weight(wy_s2)
	);

	// stages 3..6: sixteen hash lanes, row r = dy+1, column c = dx+1
	vn2c_pkg::hash_en_t hen;
	logic signed [31:0] lat_s6 [16];

	assign hen.s3 = adv[3];
	assign hen.s4 = adv[4];
	assign hen.s5 = adv[5];
	assign hen.s6 = adv[6];

	for (genvar gr = 0; gr < 4; gr++) begin : g_row
		for (genvar gc = 0; gc < 4; gc++) begin : g_col
			logic [31:0] vsum;
			logic [31:0] vmix;
			assign vsum = yt_s2[gr] + xt_s2[gc] + sab_s2;
			assign vmix = (vsum << 13) ^ vsum;
			vn2c_hash_lane u_lane (
				.clk(clk), .en(hen), .v_in(vmix), .lat_s6(lat_s6[gr*4+gc])
			);
		end
	end

	logic [WW-1:0] wx_s3, wx_s4, wx_s5, wx_s6, wx_s7;
	logic [WW-1:0] wy_s3, wy_s4, wy_s5, wy_s6, wy_s7, wy_s8;

	always_ff @(posedge clk) begin
		if (adv[3]) begin wx_s3 <= wx_s2; wy_s3 <= wy_s2; end
		if (adv[4]) begin wx_s4 <= wx_s3; wy_s4 <= wy_s3; end
		if (adv[5]) begin wx_s5 <= wx_s4; wy_s5 <= wy_s4; end
		if (adv[6]) begin wx_s6 <= wx_s5; wy_s6 <= wy_s5; end
		if (adv[7]) begin wx_s7 <= wx_s6; wy_s7 <= wy_s6; end
		if (adv[8]) begin wy_s8 <= wy_s7; end
	end

	// stage 7: 3x3 smoothing of the four cells, cell index = cy*2+cx
	logic signed [SW-1:0] sm_s7 [4];

	for (genvar gy = 0; gy < 2; gy++) begin : g_cy
		for (genvar gx = 0; gx < 2; gx++) begin : g_cx
			logic signed [SW-1:0] corner, side, mid;
			assign corner = SW'(lat_s6[gy*4+gx]) + SW'(lat_s6[gy*4+gx+2])
				+ SW'(lat_s6[(gy+2)*4+gx]) + SW'(lat_s6[(gy+2)*4+gx+2]);
			assign side = SW'(lat_s6[(gy+1)*4+gx]) + SW'(lat_s6[(gy+1)*4+gx+2])
				+ SW'(lat_s6[gy*4+gx+1]) + SW'(lat_s6[(gy+2)*4+gx+1]);
			assign mid = SW'(lat_s6[(gy+1)*4+gx+1]);
			always_ff @(posedge clk) begin
				if (adv[7]) begin
					sm_s7[gy*2+gx] <= corner + (side <<< 1) + (mid <<< 2);
				end
			end
		end
	end

	// stage 8: blend in x
	logic signed [SW-1:0] bx0, bx1, r0_s8, r1_s8;

	vn2c_blend u_bx0 (.a(sm_s7[0]), .b(sm_s7[1]), .w(wx_s7), .y(bx0));
	vn2c_blend u_bx1 (.a(sm_s7[2]), .b(sm_s7[3]), .w(wx_s7), .y(bx1));

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			r0_s8 <= bx0;
			r1_s8 <= bx1;
		end
	end

	// stage 9: blend in y, offset by one half, truncate toward zero to q16
	localparam int OUTW_M1 = vn2c_pkg::OUT_W - 1;
	logic signed [SW-1:0] by;
	logic signed [SW:0]   biased;
	logic [SW:0]          bmag;
	logic [OUTW_M1:0]     qmag;
	logic signed [vn2c_pkg::OUT_W-1:0] out_s9;

	vn2c_blend u_by (.a(r0_s8), .b(r1_s8), .w(wy_s8), .y(by));

	always_comb begin
		biased = (SW+1)'(by) + (SW+1)'(64'sd1 <<< 33);
		bmag   = biased[SW] ? (SW+1)'(-biased) : (SW+1)'(biased);
		qmag   = vn2c_pkg::OUT_W'(bmag >> 18);
	end

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			out_s9 <= biased[SW] ? signed'(vn2c_pkg::OUT_W'(0) - qmag) : signed'(qmag);
		end
	end

	assign noise.noise_value = out_s9;

endmodule

FILE: bench/tb_value_noise_if.sv
// no extra interfaces needed beyond the design ones; helper package for the bench
package tb_vn2c_util_pkg;
	timeunit 1ns;
	timeprecision 1ps;
	localparam int unsigned LONG_HOLD = 60;
endpackage

FILE: bench/tb_top.sv
// testbench for the value noise block: scoreboarded stream with apb seed writes
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = 16;
	localparam int TB = 10;
	localparam int LIMIT = 400000;
	localparam logic [2:0] ADDR_SEED_A = {vn2c_pkg::REG_SEED_A, 2'b00};
	localparam logic [2:0] ADDR_SEED_B = {vn2c_pkg::REG_SEED_B, 2'b00};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	vn2c_sample_if sample ();
	vn2c_noise_if noise ();

	value_noise_2d_cosine_top #(.FRAC_BITS(FB), .WEIGHT_TABLE_BITS(TB)) dut (
		.clk(clk), .arst_n(arst_n), .sample(sample.sink), .noise(noise.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
	} point_t;

	point_t pending_points[$];
	logic signed [17:0] expected_noise[$];
	logic [31:0] seed_a = '0, seed_b = '0;
	int send_idle_pct = 0, recv_stall_pct = 0;
	bit hold_off = 1'b0;
	int errors = 0;
	int cycles = 0;

	function automatic longint lattice(logic [31:0] i, logic [31:0] j);
		logic [31:0] xs, ys, v, h;
		xs = i + 32'd7 * seed_a;
		ys = j - 32'd17 * seed_b;
		v = (ys + seed_a) * 32'd15731 + ((xs + seed_b) << 16) + seed_a * seed_b;
		v = (v << 13) ^ v;
		h = (v * (v * v * 32'd789221 + 32'd15731) + 32'd6871) & 32'h7fff_ffff;
		return longint'(1073741824) - longint'({32'd0, h});
	endfunction

	function automatic longint smooth_cell(logic [31:0] i, logic [31:0] j);
		longint c, s, m;
		c = lattice(i - 1, j - 1) + lattice(i + 1, j - 1) + lattice(i - 1, j + 1)
			+ lattice(i + 1, j + 1);
		s = lattice(i - 1, j) + lattice(i + 1, j) + lattice(i, j - 1) + lattice(i, j + 1);
		m = lattice(i, j);
		return c + 2 * s + 4 * m;
	endfunction

	function automatic longint cos_weight(longint unsigned k);
		longint unsigned th, t, s;
		th = (64'd3373259426 * k) >> (TB + 1);
		t = th;
		s = th;
		for (int m = 1; m <= 7; m++) begin
			t = (t * th) >> 30;
			t = (t * th) >> 30;
			t = t / longint'((2 * m) * (2 * m + 1));
			if (m % 2 == 1) begin
				s = (s >= t) ? s - t : 0;
			end else begin
				s = s + t;
			end
		end
		if (s > (64'd1 << 30)) s = 64'd1 << 30;
		return longint'((s * s + (64'd1 << 43)) >> 44);
	endfunction

	function automatic longint lerp_floor(longint a, longint b, longint w);
		longint v;
		v = a * (65536 - w) + b * w;
		return v >>> 16;
	endfunction

	// truncated integer part and weight index of one coordinate
	function automatic void split_coord(logic signed [31:0] raw, output logic [31:0] ip,
		output longint unsigned idx);
		longint v;
		longint unsigned mag, fr;
		v = longint'(raw);
		mag = v < 0 ? -v : v;
		fr = mag & ((64'd1 << FB) - 1);
		ip = v < 0 ? 32'd0 - 32'(mag >> FB) : 32'(mag >> FB);
		if (FB >= TB) idx = fr >> (FB - TB);
		else idx = fr << (TB - FB);
		idx &= (64'd1 << TB) - 1;
	endfunction

	function automatic logic signed [17:0] noise_of(point_t p);
		logic [31:0] ix, iy;
		longint unsigned kx, ky;
		longint wx, wy, r0, r1, r, q;
		split_coord(p.x, ix, kx);
		split_coord(p.y, iy, ky);
		wx = cos_weight(kx);
		wy = cos_weight(ky);
		r0 = lerp_floor(smooth_cell(ix, iy), smooth_cell(ix + 1, iy), wx);
		r1 = lerp_floor(smooth_cell(ix, iy + 1), smooth_cell(ix + 1, iy + 1), wx);
		r = lerp_floor(r0, r1, wy) + (64'sd1 <<< 33);
		q = r < 0 ? -((-r) >>> 18) : (r >>> 18);
		return q[17:0];
	endfunction

	// driver: offers queued points, predicts on each accepted transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample.valid <= 1'b0;
			sample.x_pos <= '0;
			sample.y_pos <= '0;
		end else begin
			if (sample.valid && sample.ready) begin
				expected_noise.push_back(noise_of('{sample.x_pos, sample.y_pos}));
				void'(pending_points.pop_front());
			end
			if (sample.valid && !sample.ready) begin
				// keep offering
			end else if (pending_points.size() > 0 && !(sample.valid && sample.ready
				&& pending_points.size() == 0) && $urandom_range(99) >= send_idle_pct) begin
				sample.valid <= 1'b1;
				sample.x_pos <= pending_points[0].x;
				sample.y_pos <= pending_points[0].y;
			end else begin
				sample.valid <= 1'b0;
			end
		end
	end

	// monitor: checks each result transaction against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise.ready <= 1'b0;
		end else begin
			if (noise.valid && noise.ready) begin
				if (expected_noise.size() == 0) begin
					$error("unexpected noise_value %0d", noise.noise_value);
					errors++;
				end else begin
					if (noise.noise_value !== expected_noise[0]) begin
						$error("noise_value expected %0d actual %0d", expected_noise[0],
							noise.noise_value);
						errors++;
					end
					void'(expected_noise.pop_front());
				end
			end
			noise.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("FAIL value_noise_2d_cosine_top");
			$finish;
		end
	end

	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (addr == ADDR_SEED_A) seed_a = data;
		else if (addr == ADDR_SEED_B) seed_b = data;
	endtask

	task automatic drain();
		while (pending_points.size() > 0 || sample.valid || expected_noise.size() > 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom();
			1: return {{16{1'($urandom_range(1))}}, 16'($urandom())};
			2: return 32'($signed($urandom_range(600)) - 300) <<< 16 | 32'($urandom_range(65535));
			default: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom())};
		endcase
	endfunction

	task automatic run_random(int n);
		for (int i = 0; i < n; i++)
			pending_points.push_back('{rand_coord(), rand_coord()});
	endtask

	initial begin
		logic [31:0] edge_vals[10] = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
			32'h0000_ffff, 32'hffff_0001, 32'h0001_0000, 32'hffff_0000, 32'h0000_8000,
			32'h0000_003f};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		// directed corners at reset seeds
		for (int i = 0; i < 10; i++)
			pending_points.push_back('{edge_vals[i], edge_vals[9 - i]});
		for (int i = 0; i < 10; i++)
			pending_points.push_back('{edge_vals[i], edge_vals[i]});
		drain();
		apb_write(ADDR_SEED_A, 32'h7fff_ffff);
		apb_write(ADDR_SEED_B, 32'h8000_0000);
		run_random(200);
		drain();
		send_idle_pct = 76;
		apb_write(ADDR_SEED_A, 32'h8000_0000);
		apb_write(ADDR_SEED_B, 32'hffff_ffff);
		run_random(180);
		drain();
		send_idle_pct = 0; recv_stall_pct = 76;
		apb_write(ADDR_SEED_A, $urandom());
		apb_write(ADDR_SEED_B, $urandom());
		run_random(180);
		drain();
		send_idle_pct = 8; recv_stall_pct = 8;
		apb_write(ADDR_SEED_A, 32'h0);
		apb_write(ADDR_SEED_B, 32'h0);
		run_random(180);
		// receiver holds off while the sender keeps offering
		send_idle_pct = 0; recv_stall_pct = 0;
		hold_off = 1'b1;
		run_random(100);
		repeat (tb_vn2c_util_pkg::LONG_HOLD) @(posedge clk);
		hold_off = 1'b0;
		drain();
		apb_write(ADDR_SEED_A, $urandom());
		apb_write(ADDR_SEED_B, $urandom());
		run_random(90);
		drain();
		if (errors == 0) begin
			$display("PASS value_noise_2d_cosine_top");
		end else begin
			$display("FAIL value_noise_2d_cosine_top");
		end
		$finish;
	end
endmodule
